>>> hw/rtl/assert_macros.svh
// Assertion helpers for the RTL files that check their own behavior.
// Both macros sample on the rising edge of clk and stay quiet while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons must hold as well.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: whenever ante holds, cons must hold in the cycle after.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/lop_pkg.sv
package lop_pkg;

    localparam int COORD_W    = 32;
    localparam int WIDE_W     = COORD_W + 3;
    localparam int NUM_AXES   = 3;
    localparam int LEVEL_W    = 4;
    localparam int MAX_LEVELS = 8;
    localparam int PATH_W     = 24;
    localparam int GROUP_W    = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int IN_DATA_W  = 2 * NUM_AXES * COORD_W;
    localparam int OUT_DATA_W = 32;

    localparam logic [COORD_W-1:0] ROOT_MIN_RST = 32'hFFC1_8000;
    localparam logic [COORD_W-1:0] ROOT_MAX_RST = 32'h003E_8000;
    localparam logic [LEVEL_W-1:0] LIMIT_RST    = 4'd8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROOT_MIN_X   = 3'd0,
        REG_ROOT_MIN_Y   = 3'd1,
        REG_ROOT_MIN_Z   = 3'd2,
        REG_ROOT_MAX_X   = 3'd3,
        REG_ROOT_MAX_Y   = 3'd4,
        REG_ROOT_MAX_Z   = 3'd5,
        REG_LEVEL_LIMIT  = 3'd6
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } ctrl_state_t;

    typedef struct packed {
        logic [NUM_AXES-1:0][COORD_W-1:0] root_min;
        logic [NUM_AXES-1:0][COORD_W-1:0] root_max;
        logic [LEVEL_W-1:0]               level_limit;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic step;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic done;
    } dp_status_t;

    // Sign-extends a coordinate to the internal working width.
    function automatic logic signed [WIDE_W-1:0] sx(input logic [COORD_W-1:0] v);
        return {{(WIDE_W - COORD_W){v[COORD_W-1]}}, v};
    endfunction

endpackage

>>> hw/rtl/lop_cfg.sv
module lop_cfg
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lop_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lop_pkg::COORD_W-1:0]    cfg_data,
    output lop_pkg::cfg_t                  cfg
);

    lop_pkg::cfg_t cfg_reg;
    lop_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                lop_pkg::REG_ROOT_MIN_X:  cfg_next.root_min[0] = cfg_data;
                lop_pkg::REG_ROOT_MIN_Y:  cfg_next.root_min[1] = cfg_data;
                lop_pkg::REG_ROOT_MIN_Z:  cfg_next.root_min[2] = cfg_data;
                lop_pkg::REG_ROOT_MAX_X:  cfg_next.root_max[0] = cfg_data;
                lop_pkg::REG_ROOT_MAX_Y:  cfg_next.root_max[1] = cfg_data;
                lop_pkg::REG_ROOT_MAX_Z:  cfg_next.root_max[2] = cfg_data;
                lop_pkg::REG_LEVEL_LIMIT:
                    cfg_next.level_limit = cfg_data[lop_pkg::LEVEL_W-1:0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < lop_pkg::NUM_AXES; a++)
            begin
                cfg_reg.root_min[a] <= lop_pkg::ROOT_MIN_RST;
                cfg_reg.root_max[a] <= lop_pkg::ROOT_MAX_RST;
            end
            cfg_reg.level_limit <= lop_pkg::LIMIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> hw/rtl/lop_dp.sv
module lop_dp
(
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  lop_pkg::cfg_t                                   cfg,
    input  logic [lop_pkg::NUM_AXES-1:0][lop_pkg::COORD_W-1:0] in_min,
    input  logic [lop_pkg::NUM_AXES-1:0][lop_pkg::COORD_W-1:0] in_max,
    input  logic                                            in_occ,
    input  lop_pkg::ctrl_cmd_t                              cmd,
    output lop_pkg::dp_status_t                             status,
    output logic [lop_pkg::LEVEL_W-1:0]                     depth,
    output logic [lop_pkg::PATH_W-1:0]                      child_path
);

    // Working octant and box, one level of descent per step.
    logic [lop_pkg::NUM_AXES-1:0][lop_pkg::COORD_W-1:0] omin_reg, omin_next;
    logic [lop_pkg::NUM_AXES-1:0][lop_pkg::COORD_W-1:0] omax_reg, omax_next;
    logic [lop_pkg::NUM_AXES-1:0][lop_pkg::COORD_W-1:0] bmin_reg, bmin_next;
    logic [lop_pkg::NUM_AXES-1:0][lop_pkg::COORD_W-1:0] bmax_reg, bmax_next;
    logic                                occ_reg, occ_next;
    logic [lop_pkg::LEVEL_W-1:0]         level_reg, level_next;
    logic [lop_pkg::LEVEL_W-1:0]         limit_reg, limit_next;
    logic [lop_pkg::PATH_W-1:0]          path_reg, path_next;
    logic [lop_pkg::LEVEL_W-1:0]         depth_reg, depth_next;
    logic [lop_pkg::PATH_W-1:0]          opath_reg, opath_next;

    logic signed [lop_pkg::WIDE_W-1:0] omin_w [lop_pkg::NUM_AXES];
    logic signed [lop_pkg::WIDE_W-1:0] omax_w [lop_pkg::NUM_AXES];
    logic signed [lop_pkg::WIDE_W-1:0] bmin_w [lop_pkg::NUM_AXES];
    logic signed [lop_pkg::WIDE_W-1:0] bmax_w [lop_pkg::NUM_AXES];
    logic signed [lop_pkg::WIDE_W-1:0] half_w [lop_pkg::NUM_AXES];
    logic signed [lop_pkg::WIDE_W-1:0] quarter_w [lop_pkg::NUM_AXES];
    logic signed [lop_pkg::WIDE_W-1:0] lmin_w [lop_pkg::NUM_AXES];
    logic signed [lop_pkg::WIDE_W-1:0] lmax_w [lop_pkg::NUM_AXES];
    logic signed [lop_pkg::WIDE_W-1:0] ocen_w [lop_pkg::NUM_AXES];
    logic signed [lop_pkg::WIDE_W-1:0] bcen_w [lop_pkg::NUM_AXES];
    logic [lop_pkg::NUM_AXES-1:0]      stay_axis;
    logic [lop_pkg::GROUP_W-1:0]       idx;
    logic                              at_root;
    logic                              stay;
    logic [lop_pkg::LEVEL_W-1:0]       limit_eff;

    assign at_root = (level_reg == '0);

    // Per-axis stay test and child selection for the current octant.
    always_comb
    begin
        for (int a = 0; a < lop_pkg::NUM_AXES; a++)
        begin
            omin_w[a]    = lop_pkg::sx(omin_reg[a]);
            omax_w[a]    = lop_pkg::sx(omax_reg[a]);
            bmin_w[a]    = lop_pkg::sx(bmin_reg[a]);
            bmax_w[a]    = lop_pkg::sx(bmax_reg[a]);
            half_w[a]    = (omax_w[a] - omin_w[a]) >>> 1;
            quarter_w[a] = half_w[a] >>> 1;
            lmin_w[a]    = omin_w[a] - half_w[a];
            lmax_w[a]    = omax_w[a] + half_w[a];
            ocen_w[a]    = (omin_w[a] + omax_w[a]) >>> 1;
            bcen_w[a]    = (bmin_w[a] + bmax_w[a]) >>> 1;
            stay_axis[a] = ((bmax_w[a] - bmin_w[a]) >= half_w[a])
                        || (bmin_w[a] <= (omin_w[a] - quarter_w[a]))
                        || (bmax_w[a] >= (omax_w[a] + quarter_w[a]))
                        || (at_root && ((bmin_w[a] < lmin_w[a]) || (bmax_w[a] > lmax_w[a])
                                     || (bmax_w[a] < lmin_w[a]) || (bmin_w[a] > lmax_w[a])));
            idx[a]       = (bcen_w[a] >= ocen_w[a]);
        end
    end

    assign stay        = (|stay_axis) || (at_root && !occ_reg);
    assign status.done = stay || (level_reg >= limit_reg);

    // A limit of zero still allows one level; anything deeper is clipped.
    always_comb
    begin
        if (cfg.level_limit == '0)
        begin
            limit_eff = lop_pkg::LEVEL_W'(1);
        end
        else if (cfg.level_limit > lop_pkg::LEVEL_W'(lop_pkg::MAX_LEVELS))
        begin
            limit_eff = lop_pkg::LEVEL_W'(lop_pkg::MAX_LEVELS);
        end
        else
        begin
            limit_eff = cfg.level_limit;
        end
    end

    always_comb
    begin
        omin_next  = omin_reg;
        omax_next  = omax_reg;
        bmin_next  = bmin_reg;
        bmax_next  = bmax_reg;
        occ_next   = occ_reg;
        level_next = level_reg;
        limit_next = limit_reg;
        path_next  = path_reg;
        depth_next = depth_reg;
        opath_next = opath_reg;

        if (cmd.load)
        begin
            omin_next  = cfg.root_min;
            omax_next  = cfg.root_max;
            bmin_next  = in_min;
            bmax_next  = in_max;
            occ_next   = in_occ;
            level_next = '0;
            limit_next = limit_eff;
            path_next  = '0;
        end
        else if (cmd.step)
        begin
            for (int a = 0; a < lop_pkg::NUM_AXES; a++)
            begin
                if (idx[a])
                begin
                    omin_next[a] = ocen_w[a][lop_pkg::COORD_W-1:0];
                end
                else
                begin
                    omax_next[a] = ocen_w[a][lop_pkg::COORD_W-1:0];
                end
            end
            if (level_reg < lop_pkg::LEVEL_W'(lop_pkg::MAX_LEVELS))
            begin
                path_next = path_reg
                          | (lop_pkg::PATH_W'(idx) << (lop_pkg::GROUP_W * level_reg));
            end
            level_next = level_reg + lop_pkg::LEVEL_W'(1);
        end

        if (cmd.out_load)
        begin
            depth_next = level_reg;
            opath_next = path_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
            limit_reg <= lop_pkg::LIMIT_RST;
        end
        else
        begin
            level_reg <= level_next;
            limit_reg <= limit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        omin_reg  <= omin_next;
        omax_reg  <= omax_next;
        bmin_reg  <= bmin_next;
        bmax_reg  <= bmax_next;
        occ_reg   <= occ_next;
        path_reg  <= path_next;
        depth_reg <= depth_next;
        opath_reg <= opath_next;
    end

    assign depth      = depth_reg;
    assign child_path = opath_reg;

endmodule

>>> hw/rtl/lop_ctrl.sv
module lop_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  lop_pkg::dp_status_t  status,
    output lop_pkg::ctrl_cmd_t   cmd
);

    lop_pkg::ctrl_state_t state_reg, state_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_free;

    // The result register can take a new beat when empty or being drained.
    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lop_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = lop_pkg::ST_RUN;
                end
            end
            lop_pkg::ST_RUN:
            begin
                if (status.done)
                begin
                    state_next = out_free ? lop_pkg::ST_IDLE : lop_pkg::ST_HOLD;
                end
            end
            lop_pkg::ST_HOLD:
            begin
                if (out_free)
                begin
                    state_next = lop_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lop_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            lop_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            lop_pkg::ST_RUN:
            begin
                cmd.step     = !status.done;
                cmd.out_load = status.done && out_free;
            end
            lop_pkg::ST_HOLD:
            begin
                cmd.out_load = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lop_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

>>> hw/rtl/loose_octree_placement.sv
// Loose octree placement: each input beat carries one axis-aligned box and an occludee
// flag, and each output beat reports the octant that should hold the box, as a depth
// (0 is the root) and a path of 3-bit child indices, level one in the lowest bits.
// The block handles one box at a time. The accepting edge loads the box and the root
// bounds. After that, a single shared per-level unit works on each level in turn, from
// the root down to the chosen octant. At each level it tests whether the box stays or
// the level limit is reached and, if neither, narrows the octant to the chosen child.
// The input reopens as soon as the current result sits in the output register, even
// if that result has not yet been taken. If the previous result is still waiting when
// a new one is ready, the new one is held and the input stays closed until the output
// register frees up. The root bounds and level limit are written through the
// configuration port, which is always ready; write it only while no box is in flight.
// After reset the root spans -1000.0 to +1000.0 on every axis and the level limit is
// eight.

`include "assert_macros.svh"

module loose_octree_placement
(
    input  logic                                 clk,
    input  logic                                 rst_n,

    // Input boxes.
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // s_tdata, from bit 0 up: box_min_x, box_min_y, box_min_z,
    // box_max_x, box_max_y, box_max_z (32 bits each).
    input  logic [lop_pkg::IN_DATA_W-1:0]        s_tdata,
    // s_tuser: is_occludee.
    input  logic                                 s_tuser,

    // Placement results.
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // m_tdata, from bit 0 up: depth (4 bits), child_path (24 bits), 4 zero bits.
    output logic [lop_pkg::OUT_DATA_W-1:0]       m_tdata,

    // Configuration writes.
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [lop_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [lop_pkg::COORD_W-1:0]          cfg_data
);

    lop_pkg::cfg_t                                       cfg;
    lop_pkg::ctrl_cmd_t                                  cmd;
    lop_pkg::dp_status_t                                 status;
    logic [lop_pkg::NUM_AXES-1:0][lop_pkg::COORD_W-1:0]  in_min;
    logic [lop_pkg::NUM_AXES-1:0][lop_pkg::COORD_W-1:0]  in_max;
    logic [lop_pkg::LEVEL_W-1:0]                         depth;
    logic [lop_pkg::PATH_W-1:0]                          child_path;

    // Split the input beat into min and max corners.
    assign in_min = s_tdata[lop_pkg::NUM_AXES*lop_pkg::COORD_W-1:0];
    assign in_max = s_tdata[lop_pkg::IN_DATA_W-1:lop_pkg::NUM_AXES*lop_pkg::COORD_W];

    lop_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lop_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lop_dp u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_min     (in_min),
        .in_max     (in_max),
        .in_occ     (s_tuser),
        .cmd        (cmd),
        .status     (status),
        .depth      (depth),
        .child_path (child_path)
    );

    // The output beat is zero-padded up to a whole number of bytes.
    assign m_tdata = {(lop_pkg::OUT_DATA_W - lop_pkg::PATH_W - lop_pkg::LEVEL_W)'(0),
                      child_path, depth};

    // Only one box is in flight, so accepting a beat closes the input side.
    `ASSERT_NEXT(a_single_box, s_tvalid && s_tready, !s_tready, "second box accepted while busy")
    // Loading the result register always presents a beat on the next cycle.
    `ASSERT_NEXT(a_load_shows, cmd.out_load, m_tvalid, "result loaded but not presented")
    // The reported depth never exceeds the deepest level the octree supports.
    `ASSERT_SAME(a_depth_max, m_tvalid, depth <= lop_pkg::LEVEL_W'(lop_pkg::MAX_LEVELS), "depth too large")
    // A box kept at the root has an empty child path.
    `ASSERT_SAME(a_root_path, m_tvalid && (depth == '0), child_path == '0, "root result has a path")

endmodule
